[design/tts_pkg.sv]
// Shared types, codes and functions of the timer task scheduler.
package tts_pkg;

	localparam int CAPACITY_DEF  = 64;
	localparam int MAX_FIRES_DEF = 64;

	localparam logic [1:0] ACT_ADD_ONCE = 2'd0;
	localparam logic [1:0] ACT_ADD_PER  = 2'd1;
	localparam logic [1:0] ACT_CLEAR    = 2'd2;
	localparam logic [1:0] ACT_TICK     = 2'd3;

	localparam logic [2:0] ST_ADDED   = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_CLEARED = 3'd2;
	localparam logic [2:0] ST_FIRED   = 3'd3;
	localparam logic [2:0] ST_NONE    = 3'd4;

	typedef struct packed {
		logic [1:0]  action;
		logic [47:0] now;
		logic [31:0] delay;
		logic        delay_given;
		logic [31:0] period;
		logic [15:0] task_id;
	} cmd_t;

	typedef struct packed {
		logic [15:0] fired_id;
		logic [47:0] due_time;
		logic [2:0]  status;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [47:0] due;
		logic [31:0] period;
		logic [15:0] id;
	} entry_t;

	// Adds a 32-bit amount to a 48-bit time, clamping at the largest time.
	function automatic logic [47:0] sat_add48(logic [47:0] a, logic [31:0] b);
		logic [48:0] sum;
		sum = {1'b0, a} + {17'd0, b};
		return sum[48] ? {48{1'b1}} : sum[47:0];
	endfunction

endpackage

[design/timer_task_scheduler.sv]
// Top level of the timer task scheduler: a min-heap timer queue in one RAM.
// Clear and a refused add complete in the idle state; an accepted add then runs
// the sift-up loop over the one RAM read port.
// A tick sifts down after each fired task and reinserts periodic ones; each
// result is a one-cycle strobe that the receiver must take.
// Throughput: one request at a time, the next is taken once busy is low; reset empties the queue.
module timer_task_scheduler #(
	parameter int CAPACITY  = tts_pkg::CAPACITY_DEF,
	parameter int MAX_FIRES = tts_pkg::MAX_FIRES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tts_pkg::cmd_t    cmd,
	output logic             result_valid,
	output tts_pkg::result_t result
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = CW + 1;
	localparam int FW = $clog2(MAX_FIRES + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_UP, S_UP_CMP, S_TOP, S_TOP_CMP, S_LAST,
		S_DN, S_DNL, S_DNR, S_DNC, S_REINS
	} state_t;

	state_t           state_q;
	tts_pkg::cmd_t    cmd_q;
	logic             tick_q;
	logic [CW-1:0]    cnt_q;
	logic [AW-1:0]    hole_q;
	logic [AW-1:0]    best_idx_q;
	logic [FW-1:0]    fires_q;
	tts_pkg::entry_t  cur_q;
	tts_pkg::entry_t  best_q;
	tts_pkg::entry_t  fire_q;
	logic             pend_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	tts_pkg::entry_t  ram_wdata;
	logic [AW-1:0]    ram_raddr;
	tts_pkg::entry_t  ram_rdata;

	logic [AW-1:0]    parent_idx;
	logic [LW-1:0]    left_idx;
	logic [LW-1:0]    right_idx;
	logic [CW-1:0]    cnt_dec;
	logic [47:0]      add_due;
	logic             top_due;

	tts_ram #(.WIDTH($bits(tts_pkg::entry_t)), .DEPTH(CAPACITY)) u_heap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign busy       = (state_q != S_IDLE);
	assign parent_idx = AW'((hole_q - AW'(1)) >> 1);
	assign left_idx   = LW'({hole_q, 1'b1});
	assign right_idx  = left_idx + LW'(1);
	assign cnt_dec    = cnt_q - CW'(1);
	assign top_due    = (ram_rdata.due <= cmd_q.now);

	// Due time of a new task from the request fields.
	always_comb begin
		if (cmd.action == tts_pkg::ACT_ADD_ONCE) begin
			add_due = cmd.delay_given ? tts_pkg::sat_add48(cmd.now, cmd.delay) : cmd.now;
		end else begin
			add_due = tts_pkg::sat_add48(cmd.now, cmd.delay_given ? cmd.delay : cmd.period);
		end
	end

	// RAM port control for each step of the sift loops.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = hole_q;
		ram_wdata = cur_q;
		ram_raddr = '0;
		unique case (state_q)
			S_UP: begin
				if (hole_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = parent_idx;
				end
			end
			S_UP_CMP: begin
				ram_we = 1'b1;
				if (cur_q.due < ram_rdata.due) begin
					ram_wdata = ram_rdata;
				end
			end
			S_TOP_CMP: ram_raddr = cnt_dec[AW-1:0];
			S_DN: begin
				if (left_idx >= LW'(cnt_q)) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = left_idx[AW-1:0];
				end
			end
			S_DNL: ram_raddr = right_idx[AW-1:0];
			S_DNC: begin
				ram_we = 1'b1;
				if (best_q.due < cur_q.due) begin
					ram_wdata = best_q;
				end
			end
			default: ;
		endcase
	end

	// Sequencer with its registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			tick_q       <= 1'b0;
			pend_q       <= 1'b0;
			fires_q      <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						unique case (cmd.action) inside
							tts_pkg::ACT_ADD_ONCE, tts_pkg::ACT_ADD_PER: begin
								result_valid    <= 1'b1;
								result.fired_id <= cmd.task_id;
								result.due_time <= add_due;
								result.last     <= 1'b1;
								if (cnt_q >= CW'(CAPACITY)) begin
									result.status <= tts_pkg::ST_FULL;
								end else begin
									// The add result is sent now; the insert follows.
									result.status <= tts_pkg::ST_ADDED;
									cur_q.due     <= add_due;
									cur_q.period  <= (cmd.action == tts_pkg::ACT_ADD_PER) ?
									                 cmd.period : 32'd0;
									cur_q.id      <= cmd.task_id;
									hole_q        <= cnt_q[AW-1:0];
									cnt_q         <= cnt_q + CW'(1);
									tick_q        <= 1'b0;
									state_q       <= S_UP;
								end
							end
							tts_pkg::ACT_CLEAR: begin
								cnt_q           <= '0;
								result_valid    <= 1'b1;
								result.fired_id <= '0;
								result.due_time <= '0;
								result.status   <= tts_pkg::ST_CLEARED;
								result.last     <= 1'b1;
							end
							default: begin
								tick_q  <= 1'b1;
								pend_q  <= 1'b0;
								fires_q <= '0;
								state_q <= S_TOP;
							end
						endcase
					end
				end
				S_UP: begin
					if (hole_q == '0) begin
						state_q <= tick_q ? S_TOP : S_IDLE;
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (cur_q.due < ram_rdata.due) begin
						hole_q  <= parent_idx;
						state_q <= S_UP;
					end else begin
						state_q <= tick_q ? S_TOP : S_IDLE;
					end
				end
				S_TOP: begin
					if (fires_q == FW'(MAX_FIRES) || cnt_q == '0) begin
						// Close the tick: the held fire, if any, is the final result, else a none result.
						result_valid <= 1'b1;
						result.last  <= 1'b1;
						if (!pend_q) begin
							result.fired_id <= '0;
							result.due_time <= '0;
							result.status   <= tts_pkg::ST_NONE;
						end else begin
							result.fired_id <= fire_q.id;
							result.due_time <= fire_q.due;
							result.status   <= tts_pkg::ST_FIRED;
						end
						state_q <= S_IDLE;
					end else begin
						state_q <= S_TOP_CMP;
					end
				end
				S_TOP_CMP: begin
					if (top_due) begin
						// Send the previous fire now that another one follows.
						if (pend_q) begin
							result_valid    <= 1'b1;
							result.fired_id <= fire_q.id;
							result.due_time <= fire_q.due;
							result.status   <= tts_pkg::ST_FIRED;
							result.last     <= 1'b0;
						end
						pend_q  <= 1'b1;
						fire_q  <= ram_rdata;
						fires_q <= fires_q + FW'(1);
						cnt_q   <= cnt_dec;
						state_q <= (cnt_dec == '0) ? S_REINS : S_LAST;
					end else begin
						result_valid <= 1'b1;
						result.last  <= 1'b1;
						if (!pend_q) begin
							result.fired_id <= '0;
							result.due_time <= '0;
							result.status   <= tts_pkg::ST_NONE;
						end else begin
							result.fired_id <= fire_q.id;
							result.due_time <= fire_q.due;
							result.status   <= tts_pkg::ST_FIRED;
						end
						state_q <= S_IDLE;
					end
				end
				S_LAST: begin
					cur_q   <= ram_rdata;
					hole_q  <= '0;
					state_q <= S_DN;
				end
				S_DN: begin
					state_q <= (left_idx >= LW'(cnt_q)) ? S_REINS : S_DNL;
				end
				S_DNL: begin
					best_q     <= ram_rdata;
					best_idx_q <= left_idx[AW-1:0];
					state_q    <= (right_idx < LW'(cnt_q)) ? S_DNR : S_DNC;
				end
				S_DNR: begin
					// The right child wins only when strictly earlier.
					if (ram_rdata.due < best_q.due) begin
						best_q     <= ram_rdata;
						best_idx_q <= right_idx[AW-1:0];
					end
					state_q <= S_DNC;
				end
				S_DNC: begin
					if (best_q.due < cur_q.due) begin
						hole_q  <= best_idx_q;
						state_q <= S_DN;
					end else begin
						state_q <= S_REINS;
					end
				end
				S_REINS: begin
					if (fire_q.period != '0) begin
						cur_q.due    <= tts_pkg::sat_add48(fire_q.due, fire_q.period);
						cur_q.period <= fire_q.period;
						cur_q.id     <= fire_q.id;
						hole_q       <= cnt_q[AW-1:0];
						cnt_q        <= cnt_q + CW'(1);
						state_q      <= S_UP;
					end else begin
						state_q <= S_TOP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[design/tts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read of the address written in the same cycle returns the new data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && waddr == raddr) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

[dv/tb_timer_task_scheduler.sv]
// Testbench of the timer task scheduler: heap predictor, driver, monitor and checks.
module tb_timer_task_scheduler;

	localparam int QCAP      = tts_pkg::CAPACITY_DEF;
	localparam int NFIRE     = tts_pkg::MAX_FIRES_DEF;
	localparam int WDOG_MAX  = 200000;
	localparam logic [47:0] TMAX = {48{1'b1}};

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	tts_pkg::cmd_t    cmd;
	logic             result_valid;
	tts_pkg::result_t result;

	timer_task_scheduler uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.result_valid(result_valid), .result(result)
	);

	// Clock generation.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the timer heap.
	tts_pkg::entry_t  heap_q [QCAP];
	int               heap_n;
	tts_pkg::result_t expected_q[$];
	tts_pkg::cmd_t    request_q[$];
	int               mismatches;
	int               watchdog;
	bit               timed_out;
	bit               quiet_tail;
	bit               hold_for_drain;
	int               gap_left;

	function automatic logic [47:0] clamp_add(logic [47:0] a, logic [31:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {17'd0, b};
		return s[48] ? TMAX : s[47:0];
	endfunction

	function automatic void heap_swap(int a, int b);
		tts_pkg::entry_t t;
		t = heap_q[a];
		heap_q[a] = heap_q[b];
		heap_q[b] = t;
	endfunction

	function automatic void heap_push(tts_pkg::entry_t e);
		int k;
		int p;
		if (heap_n >= QCAP)
			return;
		k = heap_n;
		heap_q[k] = e;
		heap_n++;
		while (k > 0) begin
			p = (k - 1) / 2;
			if (heap_q[k].due < heap_q[p].due) begin
				heap_swap(k, p);
				k = p;
			end else
				break;
		end
	endfunction

	function automatic void heap_remove_top();
		int k;
		int l;
		int b;
		k = 0;
		if (heap_n == 0)
			return;
		heap_n--;
		if (heap_n == 0)
			return;
		heap_q[0] = heap_q[heap_n];
		forever begin
			l = 2 * k + 1;
			if (l >= heap_n)
				break;
			b = l;
			if (l + 1 < heap_n && heap_q[l + 1].due < heap_q[l].due)
				b = l + 1;
			if (heap_q[b].due < heap_q[k].due) begin
				heap_swap(k, b);
				k = b;
			end else
				break;
		end
	endfunction

	// Works out the results of one accepted request and queues them.
	function automatic void predict_request(tts_pkg::cmd_t c);
		tts_pkg::result_t r;
		tts_pkg::entry_t  e;
		int               n;
		r = '0;
		case (c.action) inside
			tts_pkg::ACT_ADD_ONCE, tts_pkg::ACT_ADD_PER: begin
				if (c.action == tts_pkg::ACT_ADD_ONCE) begin
					e.due = c.delay_given ? clamp_add(c.now, c.delay) : c.now;
					e.period = '0;
				end else begin
					e.due = clamp_add(c.now, c.delay_given ? c.delay : c.period);
					e.period = c.period;
				end
				e.id = c.task_id;
				r.fired_id = c.task_id;
				r.due_time = e.due;
				r.last = 1'b1;
				if (heap_n >= QCAP)
					r.status = tts_pkg::ST_FULL;
				else begin
					heap_push(e);
					r.status = tts_pkg::ST_ADDED;
				end
				expected_q.push_back(r);
			end
			tts_pkg::ACT_CLEAR: begin
				heap_n = 0;
				r.status = tts_pkg::ST_CLEARED;
				r.last = 1'b1;
				expected_q.push_back(r);
			end
			default: begin
				n = 0;
				while (n < NFIRE && heap_n > 0 && heap_q[0].due <= c.now) begin
					e = heap_q[0];
					r.fired_id = e.id;
					r.due_time = e.due;
					r.status = tts_pkg::ST_FIRED;
					r.last = 1'b0;
					expected_q.push_back(r);
					n++;
					heap_remove_top();
					if (e.period > 0) begin
						e.due = clamp_add(e.due, e.period);
						heap_push(e);
					end
				end
				if (n == 0) begin
					r.status = tts_pkg::ST_NONE;
					r.last = 1'b1;
					expected_q.push_back(r);
				end else
					expected_q[$].last = 1'b1;
			end
		endcase
	endfunction

	// Driver: one request per handshake, with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				predict_request(cmd);
			end
			if (start && busy) begin
				// Hold the pending request.
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (hold_for_drain && expected_q.size() != 0) begin
				start <= 1'b0;
			end else if (request_q.size() != 0 && !(start && !busy && hold_for_drain)) begin
				cmd <= request_q.pop_front();
				start <= 1'b1;
				if (!quiet_tail && $urandom_range(0, 3) == 0)
					gap_left <= int'($urandom_range(1, 7));
			end else
				start <= 1'b0;
		end
	end

	// Monitor: compares each strobed result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: got %p", result);
			end else begin
				if (result.fired_id !== expected_q[0].fired_id
						|| result.due_time !== expected_q[0].due_time
						|| result.status !== expected_q[0].status
						|| result.last !== expected_q[0].last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result mismatch: expected %p, got %p",
							expected_q[0], result);
				end
				void'(expected_q.pop_front());
			end
		end
	end

	// Watchdog on cycles with no handshake and no result.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid)
			watchdog <= 0;
		else
			watchdog <= watchdog + 1;
	end

	function automatic tts_pkg::cmd_t make_request(logic [1:0] act, logic [47:0] t,
			logic [31:0] d, logic g, logic [31:0] p, logic [15:0] id);
		tts_pkg::cmd_t c;
		c.action = act;
		c.now = t;
		c.delay = d;
		c.delay_given = g;
		c.period = p;
		c.task_id = id;
		return c;
	endfunction

	function automatic tts_pkg::cmd_t random_request(logic [47:0] t);
		tts_pkg::cmd_t c;
		int            pick;
		c = make_request(tts_pkg::ACT_ADD_ONCE, t, 32'($urandom_range(0, 2000)),
			1'($urandom_range(0, 1)),
			$urandom_range(0, 3) == 0 ? 32'd0 : 32'($urandom_range(1, 1500)),
			16'($urandom));
		pick = int'($urandom_range(0, 99));
		if (pick < 35)
			c.action = tts_pkg::ACT_ADD_ONCE;
		else if (pick < 65)
			c.action = tts_pkg::ACT_ADD_PER;
		else if (pick < 68)
			c.action = tts_pkg::ACT_CLEAR;
		else
			c.action = tts_pkg::ACT_TICK;
		// Occasional full-range noise on the delay, period and time fields.
		if ($urandom_range(0, 15) == 0) begin
			c.delay = $urandom;
			c.period = $urandom;
			c.now = {16'($urandom), 32'($urandom)};
		end
		return c;
	endfunction

	task automatic wait_drained();
		while (request_q.size() != 0 || start || expected_q.size() != 0)
			@(posedge clk);
	endtask

	// Stimulus and end of run.
	initial begin
		logic [47:0] clock_us;
		int          i;
		mismatches = 0;
		timed_out = 1'b0;
		quiet_tail = 1'b0;
		hold_for_drain = 1'b0;
		heap_n = 0;
		watchdog = 0;
		start = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		fork
			begin
				while (watchdog < WDOG_MAX)
					@(posedge clk);
				timed_out = 1'b1;
			end
			begin
				// Directed: empty tick, extremes, saturation, zero period, ties, clear.
				request_q.push_back(make_request(tts_pkg::ACT_TICK, TMAX, '0, 1'b0, '0,
					16'h0000));
				request_q.push_back(make_request(tts_pkg::ACT_ADD_ONCE, TMAX, 32'hFFFF_FFFF,
					1'b1, 32'hFFFF_FFFF, 16'hFFFF));
				request_q.push_back(make_request(tts_pkg::ACT_ADD_PER, TMAX - 48'd5, '0, 1'b0,
					32'hFFFF_FFFF, 16'h8001));
				request_q.push_back(make_request(tts_pkg::ACT_ADD_ONCE, 48'd100, 32'd50, 1'b0,
					'0, 16'h0001));
				request_q.push_back(make_request(tts_pkg::ACT_ADD_PER, 48'd0, 32'd100, 1'b1,
					'0, 16'h0002));
				request_q.push_back(make_request(tts_pkg::ACT_ADD_PER, 48'd0, '0, 1'b0,
					32'd100, 16'h0003));
				request_q.push_back(make_request(tts_pkg::ACT_ADD_PER, 48'd10, '0, 1'b1,
					32'd30, 16'h0004));
				request_q.push_back(make_request(tts_pkg::ACT_TICK, 48'd99, '0, 1'b0, '0,
					16'h0));
				request_q.push_back(make_request(tts_pkg::ACT_TICK, 48'd200, '0, 1'b0, '0,
					16'h0));
				request_q.push_back(make_request(tts_pkg::ACT_TICK, TMAX, '0, 1'b0, '0,
					16'h0));
				request_q.push_back(make_request(tts_pkg::ACT_CLEAR, '0, '0, 1'b0, '0,
					16'h0));
				request_q.push_back(make_request(tts_pkg::ACT_TICK, TMAX, '0, 1'b0, '0,
					16'h0));
				// Fill past capacity, then one tick that hits the fire limit.
				for (i = 0; i < QCAP + 2; i++)
					request_q.push_back(make_request(
						i[0] ? tts_pkg::ACT_ADD_PER : tts_pkg::ACT_ADD_ONCE,
						48'd1000, 32'(i % 5), 1'b1, 32'd7, 16'(i)));
				request_q.push_back(make_request(tts_pkg::ACT_TICK, 48'd2000, '0, 1'b0, '0,
					16'h0));
				request_q.push_back(make_request(tts_pkg::ACT_CLEAR, '0, '0, 1'b0, '0,
					16'h0));
				wait_drained();

				// Hold the sender until all results have come.
				hold_for_drain = 1'b1;
				request_q.push_back(make_request(tts_pkg::ACT_ADD_ONCE, 48'd5, 32'd1, 1'b1,
					'0, 16'h1234));
				request_q.push_back(make_request(tts_pkg::ACT_TICK, 48'd6, '0, 1'b0, '0,
					16'h0));
				wait_drained();
				hold_for_drain = 1'b0;

				// Random: time advances so that ticks find tasks due.
				clock_us = 48'd5000;
				for (i = 0; i < 240; i++) begin
					clock_us = clock_us + 48'($urandom_range(0, 400));
					if (i >= 200)
						quiet_tail = 1'b1;
					request_q.push_back(random_request(clock_us));
					if (request_q.size() > 8)
						while (request_q.size() > 2)
							@(posedge clk);
				end
				wait_drained();
				repeat (50) @(posedge clk);
			end
		join_any

		if (timed_out) begin
			$display("Mismatches found");
		end else if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
